>>> rtl/aim_pkg.sv
`timescale 1ns / 1ps

package aim_pkg;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_AFTER  = 2'd1,
      KIND_BEFORE = 2'd2,
      KIND_READ   = 2'd3
   } aim_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_INDEX = 2'd3
   } aim_status_type;

   typedef enum logic [1:0] {
      RSEL_IDX   = 2'd0,
      RSEL_SCAN  = 2'd1,
      RSEL_SHIFT = 2'd2
   } aim_rsel_type;

   typedef struct packed {
      logic           load_req;
      logic           rd_en;
      aim_rsel_type   rd_sel;
      logic           clr_scan;
      logic           inc_scan;
      logic           init_shift;
      logic           set_pos_end;
      logic           set_pos_found;
      logic           shift_write;
      logic           write_new;
      logic           rsp_load;
      aim_status_type code;
      logic           use_data;
   } aim_cmd_type;

   typedef struct packed {
      aim_kind_type kind;
      logic         full;
      logic         idx_ok;
      logic         count_zero;
      logic         match;
      logic         scan_last;
      logic         shift_done;
      logic         rsp_busy;
   } aim_stat_type;

endpackage

>>> rtl/aim_ctrl.sv
`timescale 1ns / 1ps

module aim_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aim_pkg::aim_stat_type stat,
   output aim_pkg::aim_cmd_type  cmd
);
   import aim_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type      state_ff, state_in;
   aim_status_type code_ff, code_in;
   logic           use_data_ff, use_data_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RSEL_IDX;
      cmd.code     = code_ff;
      cmd.use_data = use_data_ff;
      state_in     = state_ff;
      code_in      = code_ff;
      use_data_in  = use_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            use_data_in = 1'b0;
            code_in     = ST_OK;
            if (stat.kind == KIND_READ) begin
               if (stat.idx_ok) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = RSEL_IDX;
                  use_data_in = 1'b1;
               end else begin
                  code_in = ST_BAD_INDEX;
               end
               state_in = S_FINISH;
            end else if (stat.full) begin
               code_in  = ST_FULL;
               state_in = S_FINISH;
            end else begin
               cmd.init_shift = 1'b1;
               if (stat.kind == KIND_APPEND) begin
                  cmd.set_pos_end = 1'b1;
                  state_in        = S_SHIFT_CHK;
               end else begin
                  cmd.clr_scan = 1'b1;
                  if (stat.count_zero) begin
                     code_in  = ST_NOT_FOUND;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
            end
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RSEL_SCAN;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (stat.match) begin
               cmd.set_pos_found = 1'b1;
               state_in          = S_SHIFT_CHK;
            end else if (stat.scan_last) begin
               code_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               cmd.inc_scan = 1'b1;
               state_in     = S_SRCH_RD;
            end
         end
         S_SHIFT_CHK: begin
            if (stat.shift_done) begin
               cmd.write_new = 1'b1;
               code_in       = ST_OK;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RSEL_SHIFT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = S_SHIFT_CHK;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         code_ff     <= ST_OK;
         use_data_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         code_ff     <= code_in;
         use_data_ff <= use_data_in;
      end
   end

endmodule

>>> rtl/aim_dpath.sv
`timescale 1ns / 1ps

module aim_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  aim_pkg::aim_cmd_type                  cmd,
   output aim_pkg::aim_stat_type                 stat,
   input  aim_pkg::aim_kind_type                 req_kind,
   input  logic signed [aim_pkg::VALUE_W-1:0]    req_match_value,
   input  logic signed [aim_pkg::VALUE_W-1:0]    req_new_value,
   input  logic        [aim_pkg::INDEX_W-1:0]    req_read_index,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output aim_pkg::aim_status_type               rsp_status,
   output logic signed [aim_pkg::VALUE_W-1:0]    rsp_read_data,
   output logic        [aim_pkg::FILL_W-1:0]     rsp_fill_count
);
   import aim_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [VALUE_W-1:0] mem [CAPACITY];

   aim_kind_type        kind_ff;
   logic [VALUE_W-1:0]  match_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [VALUE_W-1:0]  rdata_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [AW-1:0]       shift_ff, shift_in;
   logic [AW-1:0]       pos_ff, pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   aim_status_type      rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_data_ff;
   logic [FILL_W-1:0]   rsp_fill_ff;

   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [VALUE_W-1:0]  wr_data;

   always_comb begin
      case (cmd.rd_sel)
         RSEL_IDX:   rd_addr = AW'(idx_ff);
         RSEL_SCAN:  rd_addr = scan_ff;
         RSEL_SHIFT: rd_addr = shift_ff - AW'(1);
         default:    rd_addr = scan_ff;
      endcase
   end

   assign wr_en   = cmd.shift_write | cmd.write_new;
   assign wr_data = cmd.shift_write ? rdata_ff : value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[shift_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      shift_in = shift_ff;
      pos_in   = pos_ff;
      if (cmd.write_new) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.clr_scan) begin
         scan_in = '0;
      end else if (cmd.inc_scan) begin
         scan_in = scan_ff + AW'(1);
      end
      if (cmd.init_shift) begin
         shift_in = AW'(count_ff);
      end else if (cmd.shift_write) begin
         shift_in = shift_ff - AW'(1);
      end
      if (cmd.set_pos_end) begin
         pos_in = AW'(count_ff);
      end else if (cmd.set_pos_found) begin
         pos_in = (kind_ff == KIND_AFTER) ? scan_ff + AW'(1) : scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      scan_ff  <= scan_in;
      shift_ff <= shift_in;
      pos_ff   <= pos_in;
      if (cmd.load_req) begin
         kind_ff  <= req_kind;
         match_ff <= req_match_value;
         value_ff <= req_new_value;
         idx_ff   <= req_read_index;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.code;
         rsp_data_ff   <= cmd.use_data ? rdata_ff : '0;
         rsp_fill_ff   <= FILL_W'(count_ff);
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.full       = (count_ff >= CW'(CAPACITY));
   assign stat.idx_ok     = (IW'(idx_ff) < IW'(count_ff));
   assign stat.count_zero = (count_ff == '0);
   assign stat.match      = (rdata_ff == match_ff);
   assign stat.scan_last  = ((CW'(scan_ff) + CW'(1)) >= count_ff);
   assign stat.shift_done = (shift_ff == pos_ff);
   assign stat.rsp_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_fill_count = rsp_fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result loaded over a stalled item");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |=> count_ff == $past(count_ff) + CW'(1))
      else $error("fill count did not advance on write");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift_write && cmd.write_new))
      else $error("two writes in one cycle");

   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_write |-> shift_ff > pos_ff)
      else $error("shift below insert position");
`endif

endmodule

>>> rtl/array_insert_at_match_unit.sv
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// req      in         req_tvalid / req_tready    req_tdata, req_tuser
// rsp      out        rsp_tvalid / rsp_tready    rsp_tdata
//
// Entries sit in one memory array, used for one read or one write per cycle.
// Read and store-full requests go from dispatch straight to the finish step.
// Append writes at fill count n. Insert with first match at m, insert position p
// (m+1 after, m before) moves entries p..n-1 up and writes at p; no match: not-found.
// Reset clears the fill count and the result valid flag; entries stay unset.
// A new item is taken while a result waits; a stalled result holds the finish step.

module array_insert_at_match_unit #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] match_value, [63:32] new_value, [69:64] read_index, [71:70] zero
   input  logic [71:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [33:2] read_data, [40:34] fill_count, [47:41] zero
   output logic [47:0] rsp_tdata
);
   import aim_pkg::*;

   aim_cmd_type            cmd;
   aim_stat_type           stat;
   aim_status_type         rsp_status;
   logic [VALUE_W-1:0]     rsp_read_data;
   logic [FILL_W-1:0]      rsp_fill_count;

   aim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   aim_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (aim_kind_type'(req_tuser)),
      .req_match_value (req_tdata[31:0]),
      .req_new_value   (req_tdata[63:32]),
      .req_read_index  (req_tdata[69:64]),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_fill_count  (rsp_fill_count)
   );

   assign rsp_tdata = {7'd0, rsp_fill_count, rsp_read_data, rsp_status};

endmodule
